### hw/rtl/hrhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_START,
        PH_KEYWORD,
        PH_METHOD_SEP,
        PH_SP1,
        PH_PATH,
        PH_SP2,
        PH_HTTP,
        PH_MAJOR,
        PH_MINOR,
        PH_LINE_END,
        PH_HDR_START,
        PH_NAME,
        PH_COLON_SP,
        PH_VALUE,
        PH_VALUE_END
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_REJECT  = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_PATH  = 2'd1,
        CLS_NAME  = 2'd2,
        CLS_VALUE = 2'd3
    } byte_class_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_SPACE_RUN    = 2'd0;
    localparam logic [1:0] CFG_MAX_NAME_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_MAX_VALUE_LENGTH = 2'd2;
    localparam int         CFG_INDEX_WIDTH      = 2;

    localparam int DEFAULT_LIMIT = 1024;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam logic [0:0] METHOD_GET  = 1'b0;
    localparam logic [0:0] METHOD_POST = 1'b1;

    localparam logic [2:0] PROTO_LEN  = 3'd5;
    localparam logic [3:0] MAX_DIGITS = 4'd11;
    localparam logic [7:0] HDR_MAX    = 8'hFF;

    localparam logic signed [15:0] BACK_MAX = 16'sh7FFF;
    localparam logic signed [15:0] BACK_MIN = 16'sh8000;

    typedef struct packed {
        logic [15:0]        prev;
        logic signed [15:0] back;
    } path_t;

    // Keyword length: GET is 3 letters, POST is 4
    function automatic logic [2:0] kw_len(input logic method);
        return (method == METHOD_POST) ? 3'd4 : 3'd3;
    endfunction

    function automatic logic [7:0] kw_char(input logic method, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (method == METHOD_POST) begin
            unique case (idx)
                3'd0:    c = 8'h50; // P
                3'd1:    c = 8'h4F; // O
                3'd2:    c = 8'h53; // S
                3'd3:    c = 8'h54; // T
                default: c = 8'h00;
            endcase
        end else begin
            unique case (idx)
                3'd0:    c = 8'h47; // G
                3'd1:    c = 8'h45; // E
                3'd2:    c = 8'h54; // T
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] proto_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48; // H
            3'd1:    c = 8'h54; // T
            3'd2:    c = 8'h54; // T
            3'd3:    c = 8'h50; // P
            3'd4:    c = 8'h2F; // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Track the last two path bytes and the climb count at each slash
    function automatic path_t path_step(input logic [15:0] prev,
                                        input logic signed [15:0] back,
                                        input logic [7:0] b);
        path_t      r;
        logic [7:0] c0;
        logic [7:0] c1;
        c0     = prev[7:0];
        c1     = prev[15:8];
        r.back = back;
        if (b == CH_SLASH) begin
            if (c0 == CH_DOT && c1 == CH_DOT) begin
                if (back != BACK_MAX) r.back = back + 16'sd1;
            end else if (c0 == CH_DOT && c1 != CH_SLASH) begin
                if (back != BACK_MIN) r.back = back - 16'sd1;
            end
        end
        r.prev = {c0, b};
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/hrhp_dec_digit.sv
`timescale 1ns / 1ps
`default_nettype none

// Saturating decimal shift-in: acc * 10 + digit, clamped to all ones.
module hrhp_dec_digit #(
    parameter int VERSION_WIDTH = 16
) (
    input  wire logic [VERSION_WIDTH-1:0] acc_in,
    input  wire logic [3:0]               digit,
    output logic      [VERSION_WIDTH-1:0] acc_out
);

    localparam int WIDE = VERSION_WIDTH + 4;

    logic [WIDE-1:0] wide_acc;
    logic [WIDE-1:0] sum;

    assign wide_acc = {4'b0000, acc_in};
    assign sum      = (wide_acc << 3) + (wide_acc << 1) + {{(WIDE-4){1'b0}}, digit};
    assign acc_out  = (sum[WIDE-1:VERSION_WIDTH] != 4'b0000) ? {VERSION_WIDTH{1'b1}}
                                                              : sum[VERSION_WIDTH-1:0];

endmodule

`default_nettype wire

### hw/rtl/http_request_header_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake          Word
// s_        in   s_valid / s_ready  data_byte, last_byte
// m_        out  m_valid / m_ready  status, byte_class, echo_byte, method,
//                                   proto_major, proto_minor, header_count
// cfg_      in   cfg_we             cfg_addr, cfg_wdata (no read-back)
//
// One byte per cycle sustained while m_ready stays high; each word gives exactly one result word.
// Each byte passes an input register, then the parse step into the
// result register. The parse step is one pass through the phase logic.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to the start of a request line with limits at their defaults.
// A stalled result holds in the output register while the input register
// still takes one more word.

module http_request_header_parser
    import hrhp_pkg::*;
#(
    parameter int VERSION_WIDTH = 16,
    parameter int LENGTH_WIDTH  = 12
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_addr,
    input  wire logic [LENGTH_WIDTH-1:0]    cfg_wdata,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_data_byte,
    input  wire logic                       s_last_byte,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [1:0]                      m_status,
    output logic [1:0]                      m_byte_class,
    output logic [7:0]                      m_echo_byte,
    output logic                            m_method,
    output logic [VERSION_WIDTH-1:0]        m_proto_major,
    output logic [VERSION_WIDTH-1:0]        m_proto_minor,
    output logic [7:0]                      m_header_count
);

    localparam logic [LENGTH_WIDTH-1:0] LIMIT_RESET = LENGTH_WIDTH'(DEFAULT_LIMIT);
    localparam logic [LENGTH_WIDTH-1:0] LEN_ZERO    = '0;
    localparam logic [LENGTH_WIDTH-1:0] LEN_ONE     = LENGTH_WIDTH'(1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [LENGTH_WIDTH-1:0] max_space_run_reg;
    logic [LENGTH_WIDTH-1:0] max_name_length_reg;
    logic [LENGTH_WIDTH-1:0] max_value_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_space_run_reg    <= LIMIT_RESET;
            max_name_length_reg  <= LIMIT_RESET;
            max_value_length_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MAX_SPACE_RUN:    max_space_run_reg    <= cfg_wdata;
                CFG_MAX_NAME_LENGTH:  max_name_length_reg  <= cfg_wdata;
                CFG_MAX_VALUE_LENGTH: max_value_length_reg <= cfg_wdata;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register and result register handshake
    // ---------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       advance;   // result register can take a word this cycle
    logic       fire;      // input word moves through the parse step

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    phase_t                  phase_reg,    phase_next;
    logic                    method_reg,   method_next;
    logic [2:0]              keyword_reg,  keyword_next;
    logic [LENGTH_WIDTH-1:0] run_reg,      run_next;
    logic [3:0]              digits_reg,   digits_next;
    logic [15:0]             prev_reg,     prev_next;
    logic signed [15:0]      back_reg,     back_next;
    logic [VERSION_WIDTH-1:0] major_reg,   major_next;
    logic [VERSION_WIDTH-1:0] minor_reg,   minor_next;
    logic [7:0]              headers_reg,  headers_next;
    logic                    finished_reg, finished_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            method_reg   <= METHOD_GET;
            keyword_reg  <= '0;
            run_reg      <= '0;
            digits_reg   <= '0;
            prev_reg     <= '0;
            back_reg     <= '0;
            major_reg    <= '0;
            minor_reg    <= '0;
            headers_reg  <= '0;
            finished_reg <= 1'b0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            method_reg   <= method_next;
            keyword_reg  <= keyword_next;
            run_reg      <= run_next;
            digits_reg   <= digits_next;
            prev_reg     <= prev_next;
            back_reg     <= back_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            headers_reg  <= headers_next;
            finished_reg <= finished_next;
        end
    end

    // ---------------------------------------------------------------
    // Parse step
    // ---------------------------------------------------------------
    logic [7:0]               b;
    logic                     is_digit;
    logic                     digits_full;
    logic [VERSION_WIDTH-1:0] major_shifted;
    logic [VERSION_WIDTH-1:0] minor_shifted;
    path_t                    path_cont;   // path byte in the middle of a path
    path_t                    path_first;  // opening slash, tracker cleared

    assign b           = in_byte_reg;
    assign is_digit    = (b >= CH_DIG0) && (b <= CH_DIG9);
    assign digits_full = (digits_reg >= MAX_DIGITS);
    assign path_cont   = path_step(prev_reg, back_reg, b);
    assign path_first  = path_step(16'h0000, 16'sd0, b);

    hrhp_dec_digit #(.VERSION_WIDTH(VERSION_WIDTH)) u_major_digit (
        .acc_in  (major_reg),
        .digit   (b[3:0]),
        .acc_out (major_shifted)
    );

    hrhp_dec_digit #(.VERSION_WIDTH(VERSION_WIDTH)) u_minor_digit (
        .acc_in  (minor_reg),
        .digit   (b[3:0]),
        .acc_out (minor_shifted)
    );

    status_t     status;
    byte_class_t byte_class;
    logic        reject;
    logic        accept;

    always_comb begin
        phase_next    = phase_reg;
        method_next   = method_reg;
        keyword_next  = keyword_reg;
        run_next      = run_reg;
        digits_next   = digits_reg;
        prev_next     = prev_reg;
        back_next     = back_reg;
        major_next    = major_reg;
        minor_next    = minor_reg;
        headers_next  = headers_reg;
        finished_next = finished_reg;
        byte_class    = CLS_OTHER;
        reject        = 1'b0;
        accept        = 1'b0;
        status        = ST_IGNORED;

        if (!finished_reg) begin
            if (b == CH_NUL) begin
                reject = 1'b1;  // end of text
            end else begin
                unique case (phase_reg)
                    PH_START: begin
                        if (b == CH_G) begin
                            method_next  = METHOD_GET;
                            keyword_next = 3'd1;
                            phase_next   = PH_KEYWORD;
                        end else if (b == CH_P) begin
                            method_next  = METHOD_POST;
                            keyword_next = 3'd1;
                            phase_next   = PH_KEYWORD;
                        end else begin
                            reject = 1'b1;
                        end
                    end
                    PH_KEYWORD: begin
                        if (keyword_reg >= kw_len(method_reg) ||
                            b != kw_char(method_reg, keyword_reg)) begin
                            reject = 1'b1;
                        end else begin
                            keyword_next = keyword_reg + 3'd1;
                            if (keyword_reg + 3'd1 >= kw_len(method_reg)) begin
                                phase_next = PH_METHOD_SEP;
                            end
                        end
                    end
                    PH_METHOD_SEP: begin
                        if (b != CH_SPACE) begin
                            reject = 1'b1;
                        end else begin
                            run_next   = LEN_ZERO;
                            phase_next = PH_SP1;
                        end
                    end
                    PH_SP1: begin
                        if (b == CH_SPACE) begin
                            if (run_reg >= max_space_run_reg) reject = 1'b1;
                            else run_next = run_reg + LEN_ONE;
                        end else if (b != CH_SLASH) begin
                            reject = 1'b1;
                        end else begin
                            prev_next  = path_first.prev;
                            back_next  = path_first.back;
                            phase_next = PH_PATH;
                            byte_class = CLS_PATH;
                        end
                    end
                    PH_PATH: begin
                        if (b == CH_SPACE) begin
                            if (back_reg > 16'sd0) begin
                                reject = 1'b1;  // path climbs above root
                            end else begin
                                run_next   = LEN_ZERO;
                                phase_next = PH_SP2;
                            end
                        end else begin
                            prev_next  = path_cont.prev;
                            back_next  = path_cont.back;
                            byte_class = CLS_PATH;
                        end
                    end
                    PH_SP2: begin
                        if (b == CH_SPACE) begin
                            if (run_reg >= max_space_run_reg) reject = 1'b1;
                            else run_next = run_reg + LEN_ONE;
                        end else if (b != proto_char(3'd0)) begin
                            reject = 1'b1;
                        end else begin
                            // first letter of the protocol tag
                            keyword_next = 3'd1;
                            phase_next   = PH_HTTP;
                        end
                    end
                    PH_HTTP: begin
                        if (keyword_reg >= PROTO_LEN || b != proto_char(keyword_reg)) begin
                            reject = 1'b1;
                        end else begin
                            keyword_next = keyword_reg + 3'd1;
                            if (keyword_reg + 3'd1 >= PROTO_LEN) begin
                                phase_next  = PH_MAJOR;
                                digits_next = '0;
                            end
                        end
                    end
                    PH_MAJOR: begin
                        if (b == CH_DOT) begin
                            phase_next  = PH_MINOR;
                            digits_next = '0;
                        end else if (!is_digit || digits_full) begin
                            reject = 1'b1;
                        end else begin
                            digits_next = digits_reg + 4'd1;
                            major_next  = major_shifted;
                        end
                    end
                    PH_MINOR: begin
                        if (b == CH_SPACE || b == CH_CR || b == CH_LF) begin
                            phase_next = PH_LINE_END;
                            run_next   = LEN_ZERO;
                        end else if (!is_digit || digits_full) begin
                            reject = 1'b1;
                        end else begin
                            digits_next = digits_reg + 4'd1;
                            minor_next  = minor_shifted;
                        end
                    end
                    PH_LINE_END: begin
                        if (b == CH_SPACE || b == CH_CR) begin
                            if (run_reg >= max_space_run_reg) reject = 1'b1;
                            else run_next = run_reg + LEN_ONE;
                        end else if (b == CH_LF) begin
                            phase_next = PH_HDR_START;
                        end else begin
                            reject = 1'b1;
                        end
                    end
                    PH_HDR_START: begin
                        if (b == CH_CR || b == CH_LF) begin
                            accept = 1'b1;  // blank line ends the header block
                        end else if (b == CH_COLON) begin
                            if (headers_reg != HDR_MAX) headers_next = headers_reg + 8'd1;
                            run_next   = LEN_ZERO;
                            phase_next = PH_COLON_SP;
                        end else if (max_name_length_reg == LEN_ZERO) begin
                            reject = 1'b1;
                        end else begin
                            run_next   = LEN_ONE;
                            phase_next = PH_NAME;
                            byte_class = CLS_NAME;
                        end
                    end
                    PH_NAME: begin
                        if (b == CH_COLON) begin
                            if (headers_reg != HDR_MAX) headers_next = headers_reg + 8'd1;
                            run_next   = LEN_ZERO;
                            phase_next = PH_COLON_SP;
                        end else if (run_reg >= max_name_length_reg) begin
                            reject = 1'b1;
                        end else begin
                            run_next   = run_reg + LEN_ONE;
                            byte_class = CLS_NAME;
                        end
                    end
                    PH_COLON_SP: begin
                        if (b == CH_SPACE) begin
                            if (run_reg >= max_space_run_reg) reject = 1'b1;
                            else run_next = run_reg + LEN_ONE;
                        end else if (b == CH_CR || b == CH_LF) begin
                            run_next   = LEN_ZERO;
                            phase_next = PH_VALUE_END;
                        end else if (max_value_length_reg == LEN_ZERO) begin
                            reject = 1'b1;
                        end else begin
                            run_next   = LEN_ONE;
                            phase_next = PH_VALUE;
                            byte_class = CLS_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        if (b == CH_CR || b == CH_LF) begin
                            run_next   = LEN_ZERO;
                            phase_next = PH_VALUE_END;
                        end else if (run_reg >= max_value_length_reg) begin
                            reject = 1'b1;
                        end else begin
                            run_next   = run_reg + LEN_ONE;
                            byte_class = CLS_VALUE;
                        end
                    end
                    PH_VALUE_END: begin
                        if (b == CH_CR) begin
                            if (run_reg >= max_space_run_reg) reject = 1'b1;
                            else run_next = run_reg + LEN_ONE;
                        end else if (b == CH_LF) begin
                            phase_next = PH_HDR_START;
                        end else begin
                            reject = 1'b1;
                        end
                    end
                    default: reject = 1'b1;
                endcase
            end

            // A rejecting byte leaves the parse state as it was
            if (reject) begin
                phase_next   = phase_reg;
                method_next  = method_reg;
                keyword_next = keyword_reg;
                run_next     = run_reg;
                digits_next  = digits_reg;
                prev_next    = prev_reg;
                back_next    = back_reg;
                major_next   = major_reg;
                minor_next   = minor_reg;
                headers_next = headers_reg;
            end

            priority if (reject) begin
                status = ST_REJECT;
            end else if (accept) begin
                status = ST_ACCEPT;
            end else if (in_last_reg) begin
                status = ST_REJECT;  // buffer ran out mid-request
            end else begin
                status = ST_BUSY;
            end

            if (status != ST_BUSY) begin
                finished_next = 1'b1;
                byte_class    = CLS_OTHER;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (fire) begin
            m_status       <= status;
            m_byte_class   <= byte_class;
            m_echo_byte    <= b;
            m_method       <= method_next;
            m_proto_major  <= major_next;
            m_proto_minor  <= minor_next;
            m_header_count <= headers_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/hrhp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hrhp_checker
    import hrhp_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_status,
    input wire logic [1:0] m_byte_class,
    input wire logic [7:0] m_echo_byte,
    input wire logic [7:0] m_header_count
);

    logic       done_seen_reg;
    logic [7:0] hdr_seen_reg;
    logic       m_fire;

    assign m_fire = m_valid && m_ready;

    // Remember whether a final verdict went out, and the last header count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_seen_reg <= 1'b0;
            hdr_seen_reg  <= '0;
        end else if (m_fire) begin
            if (m_status == ST_ACCEPT || m_status == ST_REJECT) done_seen_reg <= 1'b1;
            hdr_seen_reg <= m_header_count;
        end
    end

    // After a verdict every word is ignored
    a_ignored_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && done_seen_reg |-> m_status == ST_IGNORED)
        else $error("result after verdict not marked ignored");

    // Header count never goes backward within a request
    a_hdr_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire |-> m_header_count >= hdr_seen_reg)
        else $error("header count decreased");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_echo_byte)
                                && $stable(m_byte_class))
        else $error("stalled result changed");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind http_request_header_parser hrhp_checker u_hrhp_checker (.*);

`default_nettype wire
